### hw/rtl/pltwd_pkg.sv
// shared types and constants for the page lock table
package pltwd_pkg;
	localparam int TableSlotsDef = 64;
	localparam int TxnCountDef = 16;
	localparam int PageBitsDef = 32;

	localparam logic [1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;

	localparam logic [2:0] ST_GRANTED = 3'd0;
	localparam logic [2:0] ST_HELD    = 3'd1;
	localparam logic [2:0] ST_WAIT    = 3'd2;
	localparam logic [2:0] ST_ABORT   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_OUT
	} state_t;
endpackage

### hw/rtl/pltwd_if.sv
// valid/ready channel interface
interface pltwd_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/page_lock_table_wait_die_unit.sv
// page lock table with shared/exclusive modes and wait-die conflict handling
//
// One command is taken at a time. Every command walks the slot table once,
// one slot per cycle through a single registered read port, so a release or
// query goes from one accepted transfer to the next through accept, read
// setup, the slot scan, decide and result. Every acquire also passes through
// a write state between decide and result, whether or not it changes a slot.
// The result waits in an output register until transferred, so an output
// stall holds it there, then the next command is accepted. Input payload packs
// {lock_mode, page_id, txn_id, command}; output payload packs {holds_any, status}.
// Used and exclusive-valid bits live in flip-flops cleared at reset; page,
// owner and holder mask live in a memory written one slot per cycle.
module page_lock_table_wait_die_unit
	import pltwd_pkg::*;
#(
	parameter int TABLE_SLOTS = TableSlotsDef,
	parameter int TXN_COUNT = TxnCountDef,
	parameter int PAGE_BITS = PageBitsDef
) (
	input logic clk,
	input logic arst_n,
	pltwd_if.sink in_ch,
	pltwd_if.source out_ch
);
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int TW = $clog2(TXN_COUNT);
	localparam int EW = PAGE_BITS + TW + TXN_COUNT;

	// input fields
	logic [1:0] cmd_in;
	logic [3:0] txn_in;
	logic [31:0] page_in;
	logic mode_in;
	assign cmd_in = in_ch.data[1:0];
	assign txn_in = in_ch.data[5:2];
	assign page_in = in_ch.data[37:6];
	assign mode_in = in_ch.data[38];

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	logic [3:0] txn_q;
	logic [PAGE_BITS-1:0] page_q;
	logic mode_q;
	logic [SW:0] idx_q;      // address being read
	logic [SW-1:0] rd_slot_q; // slot of registered read data
	logic rd_vld_q;
	logic hit_q, free_q;
	logic [SW-1:0] hit_slot_q, free_slot_q;
	logic [TW-1:0] hit_own_q;
	logic [TXN_COUNT-1:0] hit_mask_q;
	logic any_q;
	logic [2:0] status_q;
	logic holds_q;
	logic out_valid_q;

	logic [TABLE_SLOTS-1:0] used_q, xv_q;
	logic [EW-1:0] mem [TABLE_SLOTS];
	logic [EW-1:0] rdata_q;

	// write port driven by the sequencer
	logic we;
	logic [SW-1:0] waddr;
	logic [EW-1:0] wdata;

	// decoded read data
	logic [PAGE_BITS-1:0] r_page;
	logic [TW-1:0] r_own;
	logic [TXN_COUNT-1:0] r_mask;
	assign r_page = rdata_q[EW-1 -: PAGE_BITS];
	assign r_own = rdata_q[TXN_COUNT +: TW];
	assign r_mask = rdata_q[TXN_COUNT-1:0];

	logic txn_ok;
	logic [TW-1:0] txn_t;
	logic [TXN_COUNT-1:0] me;
	assign txn_ok = ({28'd0, txn_q} < 32'(TXN_COUNT));
	assign txn_t = TW'(txn_q);
	assign me = txn_ok ? (TXN_COUNT'(1) << txn_t) : '0;

	logic last_read;
	assign last_read = (idx_q == (SW+1)'(TABLE_SLOTS));

	// slot currently at the read output
	logic r_used, r_xv, r_mine;
	logic [TXN_COUNT-1:0] r_mask_new;
	logic r_xv_new;
	assign r_used = used_q[rd_slot_q];
	assign r_xv = xv_q[rd_slot_q];
	assign r_mine = ((r_mask & me) != '0) || (r_xv && r_own == txn_t && txn_ok);
	assign r_mask_new = r_mask & ~me;
	assign r_xv_new = r_xv && !(r_own == txn_t && txn_ok);

	// decision for acquire, from the matched slot
	logic [TXN_COUNT-1:0] others;
	logic [TXN_COUNT-1:0] older;
	logic d_xv_mine, conflict_abort;
	logic [2:0] acq_status;
	logic acq_write_new, acq_write_hit;
	always_comb begin
		d_xv_mine = xv_q[hit_slot_q] && hit_own_q == txn_t;
		others = hit_mask_q & ~me;
		if (xv_q[hit_slot_q])
			others = others | (TXN_COUNT'(1) << hit_own_q);
		// older transactions are those numbered at or below the requester
		older = (me << 1) - TXN_COUNT'(1);
		conflict_abort = (others & older) != '0;
		acq_write_new = 1'b0;
		acq_write_hit = 1'b0;
		if (!txn_ok) begin
			acq_status = ST_ABORT;
		end else if (!hit_q) begin
			acq_status = free_q ? ST_GRANTED : ST_FULL;
			acq_write_new = free_q;
		end else if (d_xv_mine || (!mode_q && (hit_mask_q & me) != '0)) begin
			acq_status = ST_HELD;
		end else if (!xv_q[hit_slot_q] && (!mode_q || others == '0)) begin
			acq_status = ST_GRANTED;
			acq_write_hit = 1'b1;
		end else begin
			acq_status = conflict_abort ? ST_ABORT : ST_WAIT;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_ch.valid) state_d = S_READ;
			S_READ:   state_d = S_SCAN;
			S_SCAN:   if (last_read) state_d = S_DECIDE;
			S_DECIDE: state_d = (cmd_q == CMD_ACQUIRE) ? S_WRITE : S_OUT;
			S_WRITE:  state_d = S_OUT;
			S_OUT:    if (out_ch.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory write selection: release writes per slot during scan, acquire at most once
	always_comb begin
		we = 1'b0;
		waddr = rd_slot_q;
		wdata = {r_page, r_own, r_mask_new};
		if (state_q == S_SCAN && rd_vld_q && cmd_q == CMD_RELEASE && r_used) begin
			we = 1'b1;
		end else if (state_q == S_WRITE && acq_write_new) begin
			we = 1'b1;
			waddr = free_slot_q;
			wdata = {page_q, txn_t, mode_q ? TXN_COUNT'(0) : me};
		end else if (state_q == S_WRITE && acq_write_hit) begin
			we = 1'b1;
			waddr = hit_slot_q;
			wdata = {page_q, txn_t, mode_q ? (hit_mask_q & ~me) : (hit_mask_q | me)};
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = {holds_q, status_q};

	// memory with registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[idx_q[SW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			cmd_q <= cmd_in;
			txn_q <= txn_in;
			page_q <= PAGE_BITS'(page_in);
			mode_q <= mode_in;
		end
		rd_slot_q <= idx_q[SW-1:0];
		if (state_q == S_SCAN && rd_vld_q && r_used && !hit_q && r_page == page_q) begin
			hit_slot_q <= rd_slot_q;
			hit_own_q <= r_own;
			hit_mask_q <= r_mask;
		end
		if (state_q == S_SCAN && rd_vld_q && !r_used && !free_q)
			free_slot_q <= rd_slot_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			rd_vld_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			any_q <= 1'b0;
			used_q <= '0;
			xv_q <= '0;
			status_q <= ST_DONE;
			holds_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					rd_vld_q <= 1'b0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
					any_q <= 1'b0;
				end
				S_READ: begin
					idx_q <= idx_q + (SW+1)'(1);
					rd_vld_q <= 1'b1;
				end
				S_SCAN: begin
					if (!last_read)
						idx_q <= idx_q + (SW+1)'(1);
					if (rd_vld_q && r_used) begin
						if (!hit_q && r_page == page_q)
							hit_q <= 1'b1;
						if (r_mine)
							any_q <= 1'b1;
						if (cmd_q == CMD_RELEASE && txn_ok) begin
							xv_q[rd_slot_q] <= r_xv_new;
							if (r_mask_new == '0 && !r_xv_new)
								used_q[rd_slot_q] <= 1'b0;
						end
					end else if (rd_vld_q && !free_q) begin
						free_q <= 1'b1;
					end
					// final slot arrives on the last read cycle, then stop
					if (last_read)
						rd_vld_q <= 1'b0;
				end
				S_DECIDE: begin
					if (cmd_q == CMD_ACQUIRE) begin
						status_q <= acq_status;
						holds_q <= 1'b0;
					end else begin
						status_q <= ST_DONE;
						holds_q <= (cmd_q == CMD_QUERY) && any_q && txn_ok;
						out_valid_q <= 1'b1;
					end
				end
				S_WRITE: begin
					if (acq_write_new) begin
						used_q[free_slot_q] <= 1'b1;
						xv_q[free_slot_q] <= mode_q;
					end else if (acq_write_hit && mode_q) begin
						xv_q[hit_slot_q] <= 1'b1;
					end
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ch.ready)
						out_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

### tb/tb.sv
// testbench for the page lock table: random and directed lock traffic checked against a predictor
module tb;
	import pltwd_pkg::*;

	localparam int SLOTS = TableSlotsDef;
	localparam int TXNS = TxnCountDef;
	localparam int IN_W = 2 + 4 + 32 + 1;
	localparam int OUT_W = 3 + 1;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic        mode;
		logic [31:0] page;
		logic [3:0]  txn;
		logic [1:0]  cmd;
	} lock_req_t;

	typedef struct packed {
		logic       any;
		logic [2:0] status;
	} lock_rsp_t;

	logic clk;
	logic arst_n;

	pltwd_if #(.W(IN_W)) req_ch ();
	pltwd_if #(.W(OUT_W)) rsp_ch ();

	page_lock_table_wait_die_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(req_ch.sink),
		.out_ch(rsp_ch.source)
	);

	// predictor copy of the lock table
	bit          tbl_used [SLOTS];
	logic [31:0] tbl_page [SLOTS];
	bit          tbl_xv [SLOTS];
	logic [3:0]  tbl_xown [SLOTS];
	logic [15:0] tbl_shr [SLOTS];

	lock_req_t pending_reqs[$];
	lock_rsp_t expected_rsps[$];
	int mismatches;
	int rsp_count;
	int stall_cycles;
	int hold_off;
	bit stim_done;
	int status_seen [8];

	function automatic logic [2:0] predict_acquire(logic [3:0] txn, logic [31:0] page, bit excl);
		int hit;
		int free_slot;
		int s;
		logic [15:0] me;
		logic [15:0] others;
		hit = -1;
		free_slot = -1;
		me = 16'(1) << txn;
		for (s = 0; s < SLOTS; s++) begin
			if (tbl_used[s]) begin
				if (hit < 0 && tbl_page[s] == page) hit = s;
			end else if (free_slot < 0) begin
				free_slot = s;
			end
		end
		if (hit < 0) begin
			if (free_slot < 0) return ST_FULL;
			tbl_used[free_slot] = 1;
			tbl_page[free_slot] = page;
			tbl_xv[free_slot] = excl;
			tbl_xown[free_slot] = excl ? txn : 4'd0;
			tbl_shr[free_slot] = excl ? 16'd0 : me;
			return ST_GRANTED;
		end
		s = hit;
		if (tbl_xv[s] && tbl_xown[s] == txn) return ST_HELD;
		if (!excl && (tbl_shr[s] & me) != 0) return ST_HELD;
		others = tbl_shr[s] & ~me;
		if (tbl_xv[s]) others |= 16'(1) << tbl_xown[s];
		if (!tbl_xv[s] && (!excl || others == 0)) begin
			if (excl) begin
				tbl_shr[s] &= ~me;
				tbl_xv[s] = 1;
				tbl_xown[s] = txn;
			end else begin
				tbl_shr[s] |= me;
			end
			return ST_GRANTED;
		end
		// wait-die: any older (smaller or equal) holder forces abort
		for (int t = 0; t <= txn; t++)
			if (others[t]) return ST_ABORT;
		return ST_WAIT;
	endfunction

	function automatic lock_rsp_t predict_lock_op(lock_req_t r);
		lock_rsp_t o;
		logic [15:0] me;
		o.status = ST_DONE;
		o.any = 0;
		me = 16'(1) << r.txn;
		case (r.cmd)
			CMD_ACQUIRE: o.status = predict_acquire(r.txn, r.page, r.mode);
			CMD_RELEASE: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (!tbl_used[s]) continue;
					tbl_shr[s] &= ~me;
					if (tbl_xv[s] && tbl_xown[s] == r.txn) tbl_xv[s] = 0;
					if (tbl_shr[s] == 0 && !tbl_xv[s]) tbl_used[s] = 0;
				end
			end
			CMD_QUERY: begin
				for (int s = 0; s < SLOTS; s++)
					if (tbl_used[s] && ((tbl_shr[s] & me) != 0 ||
					    (tbl_xv[s] && tbl_xown[s] == r.txn)))
						o.any = 1;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic lock_req_t make_req(logic [1:0] cmd, logic [3:0] txn,
	                                       logic [31:0] page, bit mode);
		lock_req_t r;
		r.cmd = cmd;
		r.txn = txn;
		r.page = page;
		r.mode = mode;
		return r;
	endfunction

	// small page pool so conflicts are common; rarely a wide random page
	function automatic logic [31:0] pick_page(int pool);
		if ($urandom_range(0, 15) == 0) return $urandom;
		return 32'($urandom_range(0, pool - 1)) ^ 32'hA5A5_0000;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// stimulus queue
	initial begin
		lock_req_t r;
		int pool;
		// directed: shared grant, held, upgrade, conflicts, extremes, unused command
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd5, 32'h0000_0000, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd5, 32'h0000_0000, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd5, 32'h0000_0000, 1));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd5, 32'h0000_0000, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd0, 32'h0000_0000, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd15, 32'h0000_0000, 1));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd15, 32'hFFFF_FFFF, 1));
		pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'd0, 32'hFFFF_FFFF, 1));
		pending_reqs.push_back(make_req(CMD_QUERY, 4'd15, 32'hFFFF_FFFF, 1));
		pending_reqs.push_back(make_req(CMD_QUERY, 4'd7, 32'h0, 0));
		pending_reqs.push_back(make_req(2'd3, 4'd15, 32'hFFFF_FFFF, 1));
		pending_reqs.push_back(make_req(CMD_RELEASE, 4'd5, 32'hFFFF_FFFF, 1));
		pending_reqs.push_back(make_req(CMD_RELEASE, 4'd15, 32'h0, 0));
		pending_reqs.push_back(make_req(CMD_RELEASE, 4'd0, 32'h0, 0));
		// fill the table to reach the full status, then drain it
		for (int i = 0; i < SLOTS + 2; i++)
			pending_reqs.push_back(make_req(CMD_ACQUIRE, 4'(i % 16), 32'h1000 + i, i[0]));
		for (int t = 0; t < TXNS; t++)
			pending_reqs.push_back(make_req(CMD_RELEASE, 4'(t), $urandom,
			                                1'($urandom_range(0, 1))));
		// random: mostly acquires on a small page pool, with releases and queries
		for (int i = 0; i < 760; i++) begin
			pool = (i < 380) ? 8 : 80;
			r.txn = 4'($urandom_range(0, 15));
			r.mode = 1'($urandom_range(0, 1));
			r.page = pick_page(pool);
			case ($urandom_range(0, 19))
				0, 1, 2: r.cmd = CMD_RELEASE;
				3, 4: r.cmd = CMD_QUERY;
				5: r.cmd = 2'd3;
				default: r.cmd = CMD_ACQUIRE;
			endcase
			pending_reqs.push_back(r);
		end
		stim_done = 1;
	end

	// driver: waits a random gap before each transfer
	int gap_left;
	initial begin
		req_ch.valid = 0;
		req_ch.data = '0;
		gap_left = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 0;
			gap_left <= $urandom_range(0, 4);
		end else if (req_ch.valid && !req_ch.ready) begin
			// hold the offered item
		end else begin
			if (req_ch.valid) begin
				// the item just transferred enters the predictor
				expected_rsps.push_back(predict_lock_op(lock_req_t'(req_ch.data)));
			end
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				req_ch.valid <= 0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				req_ch.data <= pending_reqs.pop_front();
				req_ch.valid <= 1;
				// a quarter of items are forced back to back, the rest get a random gap that can also be zero
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end
		end
	end

	// receiver: random stall per result, plus one long hold-off
	int rsp_wait;
	initial rsp_ch.ready = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 0;
			rsp_wait <= 0;
			hold_off <= 0;
		end else begin
			if (rsp_count == 300 && hold_off == 0) begin
				// long stall so the block stops taking input
				hold_off <= 600;
				rsp_ch.ready <= 0;
			end else if (hold_off > 1) begin
				hold_off <= hold_off - 1;
				rsp_ch.ready <= 0;
			end else if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_wait <= $urandom_range(0, 4);
				rsp_ch.ready <= 0;
			end else if (rsp_wait > 0) begin
				rsp_wait <= rsp_wait - 1;
				rsp_ch.ready <= 0;
			end else begin
				if (hold_off == 1) hold_off <= -1;
				rsp_ch.ready <= 1;
			end
		end
	end

	// monitor: compare each transfer with the oldest expectation
	initial begin
		mismatches = 0;
		rsp_count = 0;
		stall_cycles = 0;
	end

	always @(posedge clk) begin
		lock_rsp_t got;
		lock_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = lock_rsp_t'(rsp_ch.data);
			rsp_count <= rsp_count + 1;
			status_seen[got.status] <= status_seen[got.status] + 1;
			// predictor pushes at this same edge only for items sent earlier
			if (expected_rsps.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %h", got);
			end else begin
				want = expected_rsps.pop_front();
				if (got.status !== want.status || got.any !== want.any) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch #%0d: expected status %0d any %0d, got status %0d any %0d",
						         rsp_count, want.status, want.any, got.status, got.any);
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stim_done);
		while ((pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
		       && stall_cycles < STALL_LIMIT)
			@(posedge clk);
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_rsps.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			repeat (2 * SLOTS + 20) @(posedge clk);
			$display("%0d results checked: granted %0d held %0d wait %0d abort %0d full %0d done %0d",
			         rsp_count, status_seen[ST_GRANTED], status_seen[ST_HELD],
			         status_seen[ST_WAIT], status_seen[ST_ABORT], status_seen[ST_FULL],
			         status_seen[ST_DONE]);
			if (mismatches == 0 && expected_rsps.size() == 0) begin
				$display("== PASS ==");
			end else begin
				$display("%0d mismatches", mismatches);
				$display("== FAIL ==");
			end
			$finish;
		end
	end
endmodule
